// ----- design/mbd_pkg.sv -----
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types and constants for the button debouncer with event queue.
// ----------------------------------------------------------------------------
package mbd_pkg;

   localparam int NUM_BUTTONS_DEFAULT = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam int KIND_W     = 2;
   localparam int TIME_W     = 32;
   localparam int LEVEL_W    = 8;
   localparam int INDEX_W    = 3;
   localparam int DEBOUNCE_W = 16;
   localparam int HOLD_W     = 32;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 1;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_PUSH  = 2'd1,
      KIND_POP   = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEBOUNCE = 1'b0,
      CSR_MASK     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_SCAN,
      OP_PUSH,
      OP_POP,
      OP_QUERY,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [TIME_W-1:0]    now_time;
      logic [LEVEL_W-1:0]   levels;
      logic [INDEX_W-1:0]   index;
      logic                 pressed;
   } cmd_type;

   typedef struct packed {
      logic [INDEX_W-1:0]   button;
      logic                 pressed;
      logic [TIME_W-1:0]    stamp;
   } event_type;

   typedef struct packed {
      logic                 valid;
      event_type            ev;
   } push_type;

   typedef struct packed {
      logic                 event_valid;
      logic [INDEX_W-1:0]   event_button;
      logic                 event_pressed;
      logic [TIME_W-1:0]    event_time;
      logic [HOLD_W-1:0]    hold_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PUSH,
      ST_POP,
      ST_REPLY
   } back_state_type;

endpackage

// ----- design/mbd_front.sv -----
// ----------------------------------------------------------------------------
// mbd_front
// Accepts request transactions, decodes them into commands and holds them
// in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module mbd_front #(
   parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mbd_pkg::KIND_W-1:0]      req_kind,
   input  logic [mbd_pkg::TIME_W-1:0]      req_now_time,
   input  logic [mbd_pkg::LEVEL_W-1:0]     req_levels,
   input  logic [mbd_pkg::INDEX_W-1:0]     req_index,
   input  logic [mbd_pkg::LEVEL_W-1:0]     enabled_mask,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output mbd_pkg::cmd_type                cmd
);
   import mbd_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    decoded;
   logic       index_ok;
   logic       do_write, do_read;

   always_comb begin
      index_ok         = int'(req_index) < NUM_BUTTONS;
      decoded.now_time = req_now_time;
      decoded.levels   = req_levels;
      decoded.index    = req_index;
      decoded.pressed  = enabled_mask[req_index] & req_levels[req_index];
      unique case (kind_type'(req_kind))
         KIND_TICK:  decoded.op = OP_SCAN;
         KIND_PUSH:  decoded.op = index_ok ? OP_PUSH : OP_NONE;
         KIND_POP:   decoded.op = OP_POP;
         KIND_QUERY: decoded.op = index_ok ? OP_QUERY : OP_NONE;
         default:    decoded.op = OP_NONE;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_write  = req_valid & req_ready;
   assign do_read   = cmd_valid & cmd_ready;

   always_comb begin
      wr_ptr_in = do_write ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_read ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_write} - {1'b0, do_read};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ----- design/mbd_evq.sv -----
// ----------------------------------------------------------------------------
// mbd_evq
// Ring queue of timestamped button events; a push into a full queue drops
// the oldest entry. Read data is registered.
// ----------------------------------------------------------------------------
module mbd_evq #(
   parameter int QUEUE_DEPTH = mbd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mbd_pkg::push_type    push,
   input  logic                 pop,
   output logic                 empty,
   output mbd_pkg::event_type   rd_event
);
   import mbd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   event_type        mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   event_type        rd_event_ff;
   logic [PTR_W-1:0] wr_next, rd_next;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign wr_next  = next_slot(wr_ptr_ff);
   assign rd_next  = next_slot(rd_ptr_ff);
   assign empty    = (wr_ptr_ff == rd_ptr_ff);
   assign rd_event = rd_event_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = wr_next;
         if (wr_next == rd_ptr_ff) begin
            rd_ptr_in = rd_next;
         end
      end else if (pop && !empty) begin
         rd_ptr_in = rd_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.ev;
      end
      if (pop) begin
         rd_event_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

// ----- design/mbd_back.sv -----
// ----------------------------------------------------------------------------
// mbd_back
// Executes commands: serial debounce scan, one button per cycle, direct
// pushes, pops and hold queries. Owns the response output register.
// ----------------------------------------------------------------------------
module mbd_back #(
   parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  mbd_pkg::cmd_type                  cmd,
   input  logic [mbd_pkg::DEBOUNCE_W-1:0]    debounce_time,
   input  logic [mbd_pkg::LEVEL_W-1:0]       enabled_mask,
   output mbd_pkg::push_type                 push,
   output logic                              pop,
   input  logic                              q_empty,
   input  mbd_pkg::event_type                q_event,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mbd_pkg::rsp_type                  rsp
);
   import mbd_pkg::*;

   localparam int SCAN_BUTTONS = (NUM_BUTTONS < LEVEL_W) ? NUM_BUTTONS : LEVEL_W;
   localparam int BTN_IDX_W    = (SCAN_BUTTONS > 1) ? $clog2(SCAN_BUTTONS) : 1;

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff;
   logic [BTN_IDX_W-1:0] cnt_ff, cnt_in;
   logic                 pop_hit_ff, pop_hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff;

   logic                 raw_last_ff     [SCAN_BUTTONS];
   logic                 stable_level_ff [SCAN_BUTTONS];
   logic [TIME_W-1:0]    change_time_ff  [SCAN_BUTTONS];
   logic [HOLD_W-1:0]    hold_ticks_ff   [SCAN_BUTTONS];

   logic [BTN_IDX_W-1:0] addr;
   logic                 rd_raw, rd_stable;
   logic [TIME_W-1:0]    rd_change;
   logic [HOLD_W-1:0]    rd_hold;
   logic                 cur, changed, settle, new_stable;
   logic [TIME_W-1:0]    ct, elapsed;
   logic [HOLD_W-1:0]    hold_base, hold_new;
   logic                 scan_we, last_btn, rsp_load;
   rsp_type              rsp_in;

   // shared button-state read port
   always_comb begin
      addr       = (state_ff == ST_SCAN) ? cnt_ff : cmd_ff.index[BTN_IDX_W-1:0];
      rd_raw     = raw_last_ff[addr];
      rd_stable  = stable_level_ff[addr];
      rd_change  = change_time_ff[addr];
      rd_hold    = hold_ticks_ff[addr];
      cur        = cmd_ff.levels[addr];
      changed    = (cur != rd_raw);
      ct         = changed ? cmd_ff.now_time : rd_change;
      elapsed    = cmd_ff.now_time - ct;
      settle     = (elapsed >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_time})
                   && (rd_stable != cur);
      new_stable = settle ? cur : rd_stable;
      hold_base  = (settle && cur) ? '0 : rd_hold;
      hold_new   = (new_stable && (hold_base != '1)) ? hold_base + HOLD_W'(1)
                                                      : hold_base;
      scan_we    = (state_ff == ST_SCAN) && enabled_mask[addr];
      last_btn   = (cnt_ff == BTN_IDX_W'(SCAN_BUTTONS - 1));
      rsp_load   = (state_ff == ST_REPLY) && (!rsp_valid_ff || rsp_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_SCAN:  state_in = ST_SCAN;
                  OP_PUSH:  state_in = ST_PUSH;
                  OP_POP:   state_in = ST_POP;
                  default:  state_in = ST_REPLY;
               endcase
            end
         end
         ST_SCAN:  if (last_btn) state_in = ST_REPLY;
         ST_PUSH:  state_in = ST_REPLY;
         ST_POP:   state_in = ST_REPLY;
         ST_REPLY: if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_ready  = (state_ff == ST_IDLE);
      pop        = (state_ff == ST_POP) && !q_empty;
      push.valid = (scan_we && settle) || (state_ff == ST_PUSH);
      if (state_ff == ST_PUSH) begin
         push.ev.button  = cmd_ff.index;
         push.ev.pressed = cmd_ff.pressed;
      end else begin
         push.ev.button  = INDEX_W'(addr);
         push.ev.pressed = cur;
      end
      push.ev.stamp = cmd_ff.now_time;
      cnt_in        = (state_ff == ST_SCAN) ? cnt_ff + BTN_IDX_W'(1) : '0;
      pop_hit_in    = (state_ff == ST_POP) ? !q_empty : pop_hit_ff;

      rsp_in = '0;
      if (cmd_ff.op == OP_POP && pop_hit_ff) begin
         rsp_in.event_valid   = 1'b1;
         rsp_in.event_button  = q_event.button;
         rsp_in.event_pressed = q_event.pressed;
         rsp_in.event_time    = q_event.stamp;
      end
      if (cmd_ff.op == OP_QUERY) begin
         rsp_in.hold_count = rd_hold;
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pop_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pop_hit_ff   <= pop_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready) begin
         cmd_ff <= cmd;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SCAN_BUTTONS; i++) begin
            raw_last_ff[i]     <= 1'b0;
            stable_level_ff[i] <= 1'b0;
            change_time_ff[i]  <= '0;
            hold_ticks_ff[i]   <= '0;
         end
      end else if (scan_we) begin
         raw_last_ff[addr]     <= cur;
         stable_level_ff[addr] <= new_stable;
         change_time_ff[addr]  <= ct;
         hold_ticks_ff[addr]   <= hold_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- design/multi_button_debouncer_event_queue.sv -----
// ----------------------------------------------------------------------------
// multi_button_debouncer_event_queue
// Debounces up to eight buttons and queues timestamped press/release events.
//
// req channel: one transaction per item; tuser carries the kind (tick, direct
// push, pop, hold query), tdata the time, raw levels and button index.
// rsp channel: exactly one transaction per request, in request order.
// csr port: write-only; index 0 debounce time, index 1 enable mask.
// In the back end a tick runs the serial button scan, push and pop pass
// through their own state, and a hold query or an ignored item goes straight
// to the reply state. The response is visible the cycle after its load.
// A two-entry command queue keeps accepting requests while the back end
// works or the response register waits.
// Reset clears button state, queue pointers and rsp_tvalid and raises
// req_tready; debounce time returns to 20 and the enable mask to zero.
// A stalled rsp holds its data; the back end then waits, and requests are
// taken until the command queue fills.
// ----------------------------------------------------------------------------
module multi_button_debouncer_event_queue #(
   parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEFAULT,
   parameter int QUEUE_DEPTH = mbd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // now_time[31:0], button_levels[39:32], button_index[42:40], zero pad
   input  logic [mbd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind[1:0]
   input  logic [mbd_pkg::KIND_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // event_button[2:0], event_pressed[3], event_time[35:4],
   // hold_count[67:36], zero pad
   output logic [mbd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // event_valid[0]
   output logic [mbd_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [mbd_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mbd_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [LEVEL_W-1:0]    mask_ff, mask_in;

   logic      cmd_valid, cmd_ready;
   cmd_type   cmd;
   push_type  push;
   logic      pop, q_empty;
   event_type q_event;
   rsp_type   rsp;

   always_comb begin
      debounce_in = debounce_ff;
      mask_in     = mask_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE: debounce_in = csr_wdata;
            CSR_MASK:     mask_in     = csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         mask_ff     <= '0;
      end else begin
         debounce_ff <= debounce_in;
         mask_ff     <= mask_in;
      end
   end

   mbd_front #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser),
      .req_now_time (req_tdata[31:0]),
      .req_levels   (req_tdata[39:32]),
      .req_index    (req_tdata[42:40]),
      .enabled_mask (mask_ff),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd)
   );

   mbd_evq #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_evq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .empty    (q_empty),
      .rd_event (q_event)
   );

   mbd_back #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd),
      .debounce_time (debounce_ff),
      .enabled_mask  (mask_ff),
      .push          (push),
      .pop           (pop),
      .q_empty       (q_empty),
      .q_event       (q_event),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp           (rsp)
   );

   assign rsp_tdata = {4'b0000, rsp.hold_count, rsp.event_time,
                       rsp.event_pressed, rsp.event_button};
   assign rsp_tuser = rsp.event_valid;

endmodule
